FILE: src/t16cag_pkg.sv
// shared constants and types for the 16x16 composite tile address generator
package t16cag_pkg;

  localparam int COMPOSITE_SIZE = 16;
  localparam int CSIZE_LOG2     = $clog2(COMPOSITE_SIZE);
  localparam int PART_SIDE      = 8;
  localparam int PART_PIXELS    = PART_SIDE * PART_SIDE;
  localparam int PIX_CNT_W      = $clog2(PART_PIXELS);
  localparam int COMP_W         = 12;
  localparam int AW_W           = 11;
  localparam int PER_ROW_W      = AW_W - CSIZE_LOG2;
  localparam int DIV_STEPS      = COMP_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_DATA_W     = 11;

  typedef enum logic {
    REG_SHEET_BASE  = 1'b0,
    REG_ATLAS_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COMP_W-1:0]    quot;
    logic [PER_ROW_W-1:0] rem;
    logic [1:0]           quadrant;
    logic [9:0]           tile_id;
    logic                 flip_v;
    logic                 flip_h;
  } part_t;

endpackage

FILE: src/t16cag_div.sv
// front stage: holds one part and splits its composite index into atlas row and column
module t16cag_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [t16cag_pkg::COMP_W-1:0]       in_composite_index,
  input  logic [1:0]                          in_quadrant,
  input  logic [9:0]                          in_part_tile_id,
  input  logic                                in_flip_vertical,
  input  logic                                in_flip_horizontal,
  input  logic [t16cag_pkg::PER_ROW_W-1:0]    per_row,
  input  logic                                part_take,
  output logic                                part_valid,
  output t16cag_pkg::part_t                   part
);

  logic                                 busy_r;
  logic                                 done_r;
  logic [t16cag_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [t16cag_pkg::COMP_W-1:0]        q_r;
  logic [t16cag_pkg::PER_ROW_W-1:0]     rem_r;
  logic [1:0]                           quad_r;
  logic [9:0]                           id_r;
  logic                                 fv_r;
  logic                                 fh_r;
  logic [t16cag_pkg::PER_ROW_W:0]       shifted;
  logic [t16cag_pkg::PER_ROW_W:0]       diff;
  logic                                 qbit;
  logic                                 accept;

  assign in_ready = !busy_r && !done_r;
  assign accept   = in_valid && in_ready;

  assign shifted = {rem_r, q_r[t16cag_pkg::COMP_W-1]};
  assign diff    = shifted - {1'b0, per_row};
  assign qbit    = shifted >= {1'b0, per_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == t16cag_pkg::DIV_CNT_W'(t16cag_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (done_r && part_take) begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r    <= in_composite_index;
      rem_r  <= '0;
      quad_r <= in_quadrant;
      id_r   <= in_part_tile_id;
      fv_r   <= in_flip_vertical;
      fh_r   <= in_flip_horizontal;
    end else if (busy_r) begin
      q_r   <= {q_r[t16cag_pkg::COMP_W-2:0], qbit};
      rem_r <= qbit ? diff[t16cag_pkg::PER_ROW_W-1:0] : shifted[t16cag_pkg::PER_ROW_W-1:0];
    end
  end

  assign part_valid = done_r;
  assign part       = {q_r, rem_r, quad_r, id_r, fv_r, fh_r};

endmodule

FILE: src/tile16_compose_address_gen_top.sv
// top level: config registers, pixel sequencer and three-stage address pipeline
//
//  channel | direction | beat contents
//  in_     | in        | composite index, quadrant, tile id, flip flags
//  out_    | out       | source index, dest index, last pixel flag
//  cfg_    | in        | register index, write data
//
// the sequencer issues the 64 pixels of a part one per cycle while out_ready does not stall
// the index split of each part runs overlapped with the previous part
// first pixel passes the divider, sequencer and p1, p2 and out registers before out_, then one per cycle
// a stall on out_ready holds the whole pixel pipeline in place
// synchronous active-low reset empties every stage and restores the registers
module tile16_compose_address_gen_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [t16cag_pkg::COMP_W-1:0]       in_composite_index,
  input  logic [1:0]                          in_quadrant,
  input  logic [9:0]                          in_part_tile_id,
  input  logic                                in_flip_vertical,
  input  logic                                in_flip_horizontal,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [20:0]                         out_source_index,
  output logic [19:0]                         out_dst_index,
  output logic                                out_last_pixel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  t16cag_pkg::cfg_reg_t                cfg_index,
  input  logic [t16cag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [7:0]                              sheet_base_r;
  logic [t16cag_pkg::AW_W-1:0]             atlas_width_r;
  logic [t16cag_pkg::PER_ROW_W-1:0]        aw_tiles;
  logic [t16cag_pkg::PER_ROW_W-1:0]        per_row;
  t16cag_pkg::part_t                       part;
  logic                                    part_valid;
  logic                                    part_take;

  logic                                    adv;
  logic                                    issue;
  logic                                    active_r;
  logic [t16cag_pkg::PIX_CNT_W-1:0]        cnt_r;
  logic                                    cnt_last;
  logic [15:0]                             base_y_r;
  logic [t16cag_pkg::AW_W-1:0]             base_x_r;
  logic [8:0]                              sheet_r;
  logic [1:0]                              trow_r;
  logic [3:0]                              tcol_r;
  logic                                    fv_r;
  logic                                    fh_r;
  logic [2:0]                              py;
  logic [2:0]                              px;
  logic [2:0]                              sy;
  logic [2:0]                              sx;

  logic                                    p1_valid_r;
  logic [15:0]                             p1_row_r;
  logic [t16cag_pkg::AW_W-1:0]             p1_col_r;
  logic [20:0]                             p1_src_r;
  logic                                    p1_last_r;
  logic                                    p2_valid_r;
  logic [26:0]                             prod;
  logic [19:0]                             p2_prod_r;
  logic [t16cag_pkg::AW_W-1:0]             p2_col_r;
  logic [20:0]                             p2_src_r;
  logic                                    p2_last_r;
  logic                                    out_valid_r;
  logic [20:0]                             out_src_r;
  logic [19:0]                             out_dst_r;
  logic                                    out_last_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_base_r  <= '0;
      atlas_width_r <= t16cag_pkg::AW_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        t16cag_pkg::REG_SHEET_BASE:  sheet_base_r  <= cfg_data[7:0];
        t16cag_pkg::REG_ATLAS_WIDTH: atlas_width_r <= cfg_data[t16cag_pkg::AW_W-1:0];
        default: ;
      endcase
    end
  end

  // composites per atlas row, never zero
  assign aw_tiles = atlas_width_r[t16cag_pkg::AW_W-1:t16cag_pkg::CSIZE_LOG2];
  assign per_row  = (aw_tiles == '0) ? t16cag_pkg::PER_ROW_W'(1) : aw_tiles;

  t16cag_div u_div (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_composite_index (in_composite_index),
    .in_quadrant        (in_quadrant),
    .in_part_tile_id    (in_part_tile_id),
    .in_flip_vertical   (in_flip_vertical),
    .in_flip_horizontal (in_flip_horizontal),
    .per_row            (per_row),
    .part_take          (part_take),
    .part_valid         (part_valid),
    .part               (part)
  );

  // pixel sequencer
  assign adv       = !out_valid_r || out_ready;
  assign issue     = active_r && adv;
  assign cnt_last  = cnt_r == t16cag_pkg::PIX_CNT_W'(t16cag_pkg::PART_PIXELS - 1);
  assign part_take = part_valid && (!active_r || (issue && cnt_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (part_take) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_take) begin
      base_y_r <= {part.quot, part.quadrant[1], 3'b000};
      base_x_r <= {part.rem, part.quadrant[0], 3'b000};
      sheet_r  <= 9'(part.tile_id[7:6]) + 9'(sheet_base_r);
      trow_r   <= part.tile_id[5:4];
      tcol_r   <= part.tile_id[3:0];
      fv_r     <= part.flip_v;
      fh_r     <= part.flip_h;
    end
  end

  assign py = cnt_r[5:3];
  assign px = cnt_r[2:0];
  assign sy = fv_r ? ~py : py;
  assign sx = fh_r ? ~px : px;
  assign prod = 27'(p1_row_r) * 27'(atlas_width_r);

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r  <= active_r;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= p2_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_row_r  <= base_y_r + 16'(py);
      p1_col_r  <= base_x_r + t16cag_pkg::AW_W'(px);
      p1_src_r  <= {sheet_r, trow_r, sy, tcol_r, sx};
      p1_last_r <= cnt_last;
      p2_prod_r <= prod[19:0];
      p2_col_r  <= p1_col_r;
      p2_src_r  <= p1_src_r;
      p2_last_r <= p1_last_r;
      out_dst_r <= p2_prod_r + 20'(p2_col_r);
      out_src_r <= p2_src_r;
      out_last_r <= p2_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_src_r;
  assign out_dst_index    = out_dst_r;
  assign out_last_pixel   = out_last_r;

endmodule

FILE: src/t16cag_checker.sv
// port-level checks for the composite tile address generator
module t16cag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_source_index,
  input logic [19:0] out_dst_index,
  input logic        out_last_pixel
);

  // no beat shows right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // stalled beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_source_index) && $stable(out_dst_index)
      && $stable(out_last_pixel))
    else $error("out payload changed while stalled");

  // tile column stays the same within one part
  a_same_tile_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel ##1 out_valid |->
      out_source_index[6:3] == $past(out_source_index[6:3]))
    else $error("tile column changed inside a part");

endmodule

bind tile16_compose_address_gen_top t16cag_checker u_t16cag_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_source_index (out_source_index),
  .out_dst_index    (out_dst_index),
  .out_last_pixel   (out_last_pixel)
);
